// ===== src/bgi_pkg.sv =====
// types, widths and constants shared by the bilinear grid interpolator
// no dependencies

package bgi_pkg;

    localparam int BGI_MAX_MAG_DEF  = 64;
    localparam int BGI_MAX_TIME_DEF = 64;

    localparam int VAL_W      = 16;
    localparam int CNT_W      = 7;
    localparam int ROWCOL_W   = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CMP_W      = CNT_W + 2;

    localparam int FRAC_SHIFT = 16;
    localparam int POS_W      = 33;
    localparam int TPOS_W     = 32;
    localparam int FRAC_W     = 33;
    localparam int ROW_W      = 24;
    localparam int PROD1_W    = FRAC_W + VAL_W + 1;
    localparam int SUM1_W     = PROD1_W + 1;
    localparam int SH1_W      = SUM1_W - FRAC_SHIFT;
    localparam int PROD2_W    = FRAC_W + ROW_W + 1;
    localparam int SUM2_W     = PROD2_W + 1;
    localparam int SH2_W      = SUM2_W - FRAC_SHIFT;

    localparam int ROUND_HALF = 2 ** (FRAC_SHIFT - 1);
    localparam int ROW_MAX    = 2 ** (ROW_W - 1) - 1;
    localparam int ROW_MIN    = -(2 ** (ROW_W - 1));
    localparam int VAL_MAX    = 2 ** VAL_W - 1;

    localparam logic [CNT_W-1:0] MAG_COUNT_RST  = 7'd64;
    localparam logic [CNT_W-1:0] TIME_COUNT_RST = 7'd64;
    localparam logic [VAL_W-1:0] MAG_ORIGIN_RST = 16'h0000;
    localparam logic [VAL_W-1:0] STEP_INV_RST   = 16'h0100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAG_COUNT     = 3'd0,
        CFG_TIME_COUNT    = 3'd1,
        CFG_MAG_ORIGIN    = 3'd2,
        CFG_MAG_STEP_INV  = 3'd3,
        CFG_TIME_STEP_INV = 3'd4
    } t_cfg_index;

    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_QUERY = 1'b1
    } t_req_type;

    typedef struct packed {
        logic signed [VAL_W-1:0] mag_origin;
        logic        [VAL_W-1:0] mag_step_inv;
        logic        [VAL_W-1:0] time_step_inv;
    } t_cfg;

    typedef struct packed {
        logic time_odd;
        logic mag_odd;
    } t_corner_sel;

    typedef struct packed {
        logic [VAL_W-1:0] g00;
        logic [VAL_W-1:0] g01;
        logic [VAL_W-1:0] g10;
        logic [VAL_W-1:0] g11;
    } t_corners;

endpackage

// ===== src/bgi_req_if.sv =====
// request channel of the bilinear grid interpolator
// depends on bgi_pkg

interface bgi_req_if import bgi_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic signed [VAL_W-1:0]   magnitude;
    logic        [VAL_W-1:0]   age;
    logic        [ROWCOL_W-1:0] row;
    logic        [ROWCOL_W-1:0] column;
    logic        [VAL_W-1:0]   grid_value;

    modport source (
        output valid, req_type, magnitude, age, row, column, grid_value,
        input  ready
    );

    modport sink (
        input  valid, req_type, magnitude, age, row, column, grid_value,
        output ready
    );
endinterface

// ===== src/bgi_rsp_if.sv =====
// result channel of the bilinear grid interpolator
// depends on bgi_pkg

interface bgi_rsp_if import bgi_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] value;

    modport source (
        output valid, value,
        input  ready
    );

    modport sink (
        input  valid, value,
        output ready
    );
endinterface

// ===== src/bilinear_grid_interpolator.sv =====
// bilinear grid interpolator, top level
// depends on bgi_pkg, bgi_req_if, bgi_rsp_if, bgi_cfg, bgi_locate, bgi_grid, bgi_blend
//
// i_req carries write requests (req_type 0: row, column, grid_value) and
// query requests (req_type 1: magnitude, age). a write stores one grid entry
// and gives no result; a query gives one value on o_rsp.
// i_cfg_we, i_cfg_index and i_cfg_data set the counts, origin and step
// reciprocals; change them only while no query is in flight.
// one request is taken every cycle while i_req.ready is high. a query result
// reaches o_rsp through the six-stage pipeline, whose first stage loads on
// the accepting edge: scaling multiply, cell search with the bank reads,
// row products, row sums, age product and age sum.
// the grid sits in four parity banks, so the four corners of a cell are
// read in the same cycle. entries hold no defined value until written.
// reset clears the pipeline and returns the registers to their defaults; no
// clearing pass runs and requests are taken from the first cycle after it.
// when o_rsp stalls, the first waiting result drops into a skid register,
// then i_req.ready falls and the whole pipeline holds until it drains.

module bilinear_grid_interpolator import bgi_pkg::*; #(
    parameter int MAX_MAG_POINTS  = BGI_MAX_MAG_DEF,
    parameter int MAX_TIME_POINTS = BGI_MAX_TIME_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bgi_req_if.sink               i_req,
    bgi_rsp_if.source             o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int MCW = $clog2(MAX_MAG_POINTS);
    localparam int TCW = $clog2(MAX_TIME_POINTS);
    localparam int MHW = (MCW > 1) ? MCW - 1 : 1;
    localparam int THW = (TCW > 1) ? TCW - 1 : 1;

    logic                     en;
    logic                     accept;
    t_cfg                     cfg;
    logic        [MCW-1:0]    mag_lim;
    logic        [TCW-1:0]    time_lim;
    logic        [MHW-1:0]    col_half_even;
    logic        [MHW-1:0]    col_half_odd;
    logic        [THW-1:0]    row_half_even;
    logic        [THW-1:0]    row_half_odd;
    t_corner_sel              sel;
    logic                     loc_valid;
    logic signed [FRAC_W-1:0] mag_frac;
    logic signed [FRAC_W-1:0] time_frac;
    t_corners                 corners;
    logic                     p_valid;
    logic        [VAL_W-1:0]  p_value;
    logic                     r_skid_valid;
    logic        [VAL_W-1:0]  r_skid_value;

    assign en          = !r_skid_valid;
    assign i_req.ready = en;
    assign accept      = i_req.valid && en;

    bgi_cfg #(
        .MAX_MAG_POINTS  (MAX_MAG_POINTS),
        .MAX_TIME_POINTS (MAX_TIME_POINTS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_mag_lim   (mag_lim),
        .o_time_lim  (time_lim)
    );

    bgi_locate #(
        .MAX_MAG_POINTS  (MAX_MAG_POINTS),
        .MAX_TIME_POINTS (MAX_TIME_POINTS)
    ) u_locate (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (en),
        .i_query         (accept && (i_req.req_type == REQ_QUERY)),
        .i_magnitude     (i_req.magnitude),
        .i_age           (i_req.age),
        .i_cfg           (cfg),
        .i_mag_lim       (mag_lim),
        .i_time_lim      (time_lim),
        .o_col_half_even (col_half_even),
        .o_col_half_odd  (col_half_odd),
        .o_row_half_even (row_half_even),
        .o_row_half_odd  (row_half_odd),
        .o_sel           (sel),
        .o_valid         (loc_valid),
        .o_mag_frac      (mag_frac),
        .o_time_frac     (time_frac)
    );

    bgi_grid #(
        .MAX_MAG_POINTS  (MAX_MAG_POINTS),
        .MAX_TIME_POINTS (MAX_TIME_POINTS)
    ) u_grid (
        .i_clk           (i_clk),
        .i_en            (en),
        .i_wr_en         (accept && (i_req.req_type == REQ_WRITE)),
        .i_wr_row        (i_req.row),
        .i_wr_col        (i_req.column),
        .i_wr_data       (i_req.grid_value),
        .i_col_half_even (col_half_even),
        .i_col_half_odd  (col_half_odd),
        .i_row_half_even (row_half_even),
        .i_row_half_odd  (row_half_odd),
        .i_sel           (sel),
        .o_corners       (corners)
    );

    bgi_blend u_blend (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (loc_valid),
        .i_mag_frac  (mag_frac),
        .i_time_frac (time_frac),
        .i_corners   (corners),
        .o_valid     (p_valid),
        .o_value     (p_value)
    );

    // skid register between the pipeline and the result channel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (o_rsp.ready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (p_valid && !o_rsp.ready) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_valid) begin
            r_skid_value <= p_value;
        end
    end

    assign o_rsp.valid = r_skid_valid || p_valid;
    assign o_rsp.value = r_skid_valid ? r_skid_value : p_value;

endmodule

// ===== src/bgi_cfg.sv =====
// configuration registers and effective cell index limits
// depends on bgi_pkg

module bgi_cfg import bgi_pkg::*; #(
    parameter int MAX_MAG_POINTS  = BGI_MAX_MAG_DEF,
    parameter int MAX_TIME_POINTS = BGI_MAX_TIME_DEF,
    localparam int MCW = $clog2(MAX_MAG_POINTS),
    localparam int TCW = $clog2(MAX_TIME_POINTS)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg,
    output logic [MCW-1:0]        o_mag_lim,
    output logic [TCW-1:0]        o_time_lim
);

    logic [CNT_W-1:0] r_mag_count;
    logic [CNT_W-1:0] r_time_count;
    logic [VAL_W-1:0] r_mag_origin;
    logic [VAL_W-1:0] r_mag_step_inv;
    logic [VAL_W-1:0] r_time_step_inv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag_count     <= MAG_COUNT_RST;
            r_time_count    <= TIME_COUNT_RST;
            r_mag_origin    <= MAG_ORIGIN_RST;
            r_mag_step_inv  <= STEP_INV_RST;
            r_time_step_inv <= STEP_INV_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_MAG_COUNT:     r_mag_count     <= i_cfg_data[CNT_W-1:0];
                CFG_TIME_COUNT:    r_time_count    <= i_cfg_data[CNT_W-1:0];
                CFG_MAG_ORIGIN:    r_mag_origin    <= i_cfg_data[VAL_W-1:0];
                CFG_MAG_STEP_INV:  r_mag_step_inv  <= i_cfg_data[VAL_W-1:0];
                CFG_TIME_STEP_INV: r_time_step_inv <= i_cfg_data[VAL_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg.mag_origin    = $signed(r_mag_origin);
    assign o_cfg.mag_step_inv  = r_mag_step_inv;
    assign o_cfg.time_step_inv = r_time_step_inv;

    // highest usable cell index: count clamped to [2, max], minus two
    always_comb begin
        if (r_mag_count < CNT_W'(2)) begin
            o_mag_lim = '0;
        end else if (CMP_W'(r_mag_count) > CMP_W'(MAX_MAG_POINTS)) begin
            o_mag_lim = MCW'(MAX_MAG_POINTS - 2);
        end else begin
            o_mag_lim = MCW'(r_mag_count - CNT_W'(2));
        end
        if (r_time_count < CNT_W'(2)) begin
            o_time_lim = '0;
        end else if (CMP_W'(r_time_count) > CMP_W'(MAX_TIME_POINTS)) begin
            o_time_lim = TCW'(MAX_TIME_POINTS - 2);
        end else begin
            o_time_lim = TCW'(r_time_count - CNT_W'(2));
        end
    end

endmodule

// ===== src/bgi_locate.sv =====
// grid position stage: scales the query, finds the cell, its fractions
// and the bank read addresses of the four corners; depends on bgi_pkg

module bgi_locate import bgi_pkg::*; #(
    parameter int MAX_MAG_POINTS  = BGI_MAX_MAG_DEF,
    parameter int MAX_TIME_POINTS = BGI_MAX_TIME_DEF,
    localparam int MCW = $clog2(MAX_MAG_POINTS),
    localparam int TCW = $clog2(MAX_TIME_POINTS),
    localparam int MHW = (MCW > 1) ? MCW - 1 : 1,
    localparam int THW = (TCW > 1) ? TCW - 1 : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_query,
    input  logic signed [VAL_W-1:0]  i_magnitude,
    input  logic        [VAL_W-1:0]  i_age,
    input  t_cfg                     i_cfg,
    input  logic        [MCW-1:0]    i_mag_lim,
    input  logic        [TCW-1:0]    i_time_lim,
    output logic        [MHW-1:0]    o_col_half_even,
    output logic        [MHW-1:0]    o_col_half_odd,
    output logic        [THW-1:0]    o_row_half_even,
    output logic        [THW-1:0]    o_row_half_odd,
    output t_corner_sel              o_sel,
    output logic                     o_valid,
    output logic signed [FRAC_W-1:0] o_mag_frac,
    output logic signed [FRAC_W-1:0] o_time_frac
);

    logic signed [VAL_W:0]       diff;
    logic signed [VAL_W:0]       step_s;
    logic signed [POS_W-1:0]     n_mpos;
    logic        [TPOS_W-1:0]    n_tpos;
    logic                        r_s1_valid;
    logic signed [POS_W-1:0]     r_mpos;
    logic        [TPOS_W-1:0]    r_tpos;
    logic        [VAL_W-1:0]     m_q;
    logic        [VAL_W-1:0]     t_q;
    logic        [MCW-1:0]       mi;
    logic        [TCW-1:0]       ti;
    logic        [MCW:0]         mi_inc;
    logic        [TCW:0]         ti_inc;
    logic signed [FRAC_W-1:0]    n_mag_frac;
    logic signed [FRAC_W-1:0]    n_time_frac;

    assign diff   = $signed({i_magnitude[VAL_W-1], i_magnitude})
                  - $signed({i_cfg.mag_origin[VAL_W-1], i_cfg.mag_origin});
    assign step_s = $signed({1'b0, i_cfg.mag_step_inv});
    assign n_mpos = POS_W'(diff) * POS_W'(step_s);
    assign n_tpos = TPOS_W'(i_age) * TPOS_W'(i_cfg.time_step_inv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_query;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mpos <= n_mpos;
            r_tpos <= n_tpos;
        end
    end

    // cell index, a negative magnitude position clamped to cell zero, both clamped to the last usable cell
    assign m_q = r_mpos[FRAC_SHIFT+VAL_W-1:FRAC_SHIFT];
    assign t_q = r_tpos[FRAC_SHIFT+VAL_W-1:FRAC_SHIFT];

    always_comb begin
        if (r_mpos[POS_W-1]) begin
            mi = '0;
        end else if (m_q > VAL_W'(i_mag_lim)) begin
            mi = i_mag_lim;
        end else begin
            mi = MCW'(m_q);
        end
        if (t_q > VAL_W'(i_time_lim)) begin
            ti = i_time_lim;
        end else begin
            ti = TCW'(t_q);
        end
    end

    assign n_mag_frac  = r_mpos - $signed(FRAC_W'({mi, 16'h0000}));
    assign n_time_frac = $signed({1'b0, r_tpos}) - $signed(FRAC_W'({ti, 16'h0000}));

    // even banks hold the corner at index+1 when the index is odd
    assign mi_inc          = {1'b0, mi} + (MCW+1)'(1);
    assign ti_inc          = {1'b0, ti} + (TCW+1)'(1);
    assign o_col_half_even = MHW'(mi_inc >> 1);
    assign o_col_half_odd  = MHW'(mi >> 1);
    assign o_row_half_even = THW'(ti_inc >> 1);
    assign o_row_half_odd  = THW'(ti >> 1);
    assign o_sel.mag_odd   = mi[0];
    assign o_sel.time_odd  = ti[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_mag_frac  <= n_mag_frac;
            o_time_frac <= n_time_frac;
        end
    end

endmodule

// ===== src/bgi_grid.sv =====
// grid store in four banks split by row and column parity, so the four
// corners of a cell are read in the same cycle; depends on bgi_pkg

module bgi_grid import bgi_pkg::*; #(
    parameter int MAX_MAG_POINTS  = BGI_MAX_MAG_DEF,
    parameter int MAX_TIME_POINTS = BGI_MAX_TIME_DEF,
    localparam int MCW = $clog2(MAX_MAG_POINTS),
    localparam int TCW = $clog2(MAX_TIME_POINTS),
    localparam int MHW = (MCW > 1) ? MCW - 1 : 1,
    localparam int THW = (TCW > 1) ? TCW - 1 : 1,
    localparam int AW  = THW + MHW
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic                i_wr_en,
    input  logic [ROWCOL_W-1:0] i_wr_row,
    input  logic [ROWCOL_W-1:0] i_wr_col,
    input  logic [VAL_W-1:0]    i_wr_data,
    input  logic [MHW-1:0]      i_col_half_even,
    input  logic [MHW-1:0]      i_col_half_odd,
    input  logic [THW-1:0]      i_row_half_even,
    input  logic [THW-1:0]      i_row_half_odd,
    input  t_corner_sel         i_sel,
    output t_corners            o_corners
);

    logic              wr_ok;
    logic [AW-1:0]     wr_addr;
    logic [VAL_W-1:0]  q [2][2];
    t_corner_sel       r_sel;

    // writes outside the grid are dropped
    assign wr_ok   = i_wr_en
                   && (CMP_W'(i_wr_row) < CMP_W'(MAX_TIME_POINTS))
                   && (CMP_W'(i_wr_col) < CMP_W'(MAX_MAG_POINTS));
    assign wr_addr = {THW'(i_wr_row >> 1), MHW'(i_wr_col >> 1)};

    for (genvar rb = 0; rb < 2; rb++) begin : g_row
        for (genvar cb = 0; cb < 2; cb++) begin : g_col
            logic [VAL_W-1:0] r_mem [2**AW];
            logic [VAL_W-1:0] r_q;
            logic [AW-1:0]    rd_addr;

            assign rd_addr = {(rb == 1) ? i_row_half_odd : i_row_half_even,
                              (cb == 1) ? i_col_half_odd : i_col_half_even};

            always_ff @(posedge i_clk) begin
                if (wr_ok && (i_wr_row[0] == 1'(rb)) && (i_wr_col[0] == 1'(cb))) begin
                    r_mem[wr_addr] <= i_wr_data;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_q <= r_mem[rd_addr];
                end
            end

            assign q[rb][cb] = r_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sel <= i_sel;
        end
    end

    // put the bank outputs back into corner order
    assign o_corners.g00 = q[r_sel.time_odd][r_sel.mag_odd];
    assign o_corners.g01 = q[r_sel.time_odd][!r_sel.mag_odd];
    assign o_corners.g10 = q[!r_sel.time_odd][r_sel.mag_odd];
    assign o_corners.g11 = q[!r_sel.time_odd][!r_sel.mag_odd];

endmodule

// ===== src/bgi_blend.sv =====
// blend pipeline: two row blends along magnitude, one along age,
// rounding and saturation; depends on bgi_pkg

module bgi_blend import bgi_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic signed [FRAC_W-1:0] i_mag_frac,
    input  logic signed [FRAC_W-1:0] i_time_frac,
    input  t_corners                 i_corners,
    output logic                     o_valid,
    output logic        [VAL_W-1:0]  o_value
);

    logic signed [VAL_W:0]       d_lo;
    logic signed [VAL_W:0]       d_hi;
    logic                        r3_valid;
    logic signed [PROD1_W-1:0]   r3_prod_lo;
    logic signed [PROD1_W-1:0]   r3_prod_hi;
    logic        [VAL_W-1:0]     r3_g00;
    logic        [VAL_W-1:0]     r3_g10;
    logic signed [FRAC_W-1:0]    r3_tf;
    logic signed [SUM1_W-1:0]    sum_lo;
    logic signed [SUM1_W-1:0]    sum_hi;
    logic signed [SH1_W-1:0]     sh_lo;
    logic signed [SH1_W-1:0]     sh_hi;
    logic                        r4_valid;
    logic signed [ROW_W-1:0]     r4_lo;
    logic signed [ROW_W-1:0]     r4_hi;
    logic signed [FRAC_W-1:0]    r4_tf;
    logic signed [ROW_W:0]       d_age;
    logic                        r5_valid;
    logic signed [PROD2_W-1:0]   r5_prod;
    logic signed [ROW_W-1:0]     r5_lo;
    logic signed [SUM2_W-1:0]    sum_age;
    logic signed [SH2_W-1:0]     sh_age;
    logic        [VAL_W-1:0]     n_value;

    function automatic logic signed [ROW_W-1:0] sat_row(input logic signed [SH1_W-1:0] v);
        logic signed [ROW_W-1:0] res;
        if (v > $signed(SH1_W'(ROW_MAX))) begin
            res = ROW_W'(ROW_MAX);
        end else if (v < $signed(SH1_W'(ROW_MIN))) begin
            res = ROW_W'(ROW_MIN);
        end else begin
            res = v[ROW_W-1:0];
        end
        return res;
    endfunction

    // row products
    assign d_lo = $signed({1'b0, i_corners.g01}) - $signed({1'b0, i_corners.g00});
    assign d_hi = $signed({1'b0, i_corners.g11}) - $signed({1'b0, i_corners.g10});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            o_valid  <= 1'b0;
        end else if (i_en) begin
            r3_valid <= i_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
            o_valid  <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_prod_lo <= PROD1_W'(i_mag_frac) * PROD1_W'(d_lo);
            r3_prod_hi <= PROD1_W'(i_mag_frac) * PROD1_W'(d_hi);
            r3_g00     <= i_corners.g00;
            r3_g10     <= i_corners.g10;
            r3_tf      <= i_time_frac;
        end
    end

    // row sums, round half up, saturate
    assign sum_lo = SUM1_W'(r3_prod_lo) + $signed(SUM1_W'({r3_g00, 16'h0000}))
                  + SUM1_W'(ROUND_HALF);
    assign sum_hi = SUM1_W'(r3_prod_hi) + $signed(SUM1_W'({r3_g10, 16'h0000}))
                  + SUM1_W'(ROUND_HALF);
    assign sh_lo  = $signed(sum_lo[SUM1_W-1:FRAC_SHIFT]);
    assign sh_hi  = $signed(sum_hi[SUM1_W-1:FRAC_SHIFT]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_lo <= sat_row(sh_lo);
            r4_hi <= sat_row(sh_hi);
            r4_tf <= r3_tf;
        end
    end

    // age product
    assign d_age = (ROW_W+1)'(r4_hi) - (ROW_W+1)'(r4_lo);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_prod <= PROD2_W'(r4_tf) * PROD2_W'(d_age);
            r5_lo   <= r4_lo;
        end
    end

    assign sum_age = SUM2_W'(r5_prod) + SUM2_W'($signed({r5_lo, 16'h0000}))
                   + SUM2_W'(ROUND_HALF);
    assign sh_age  = $signed(sum_age[SUM2_W-1:FRAC_SHIFT]);

    always_comb begin
        if (sh_age < $signed(SH2_W'(0))) begin
            n_value = '0;
        end else if (sh_age > $signed(SH2_W'(VAL_MAX))) begin
            n_value = VAL_W'(VAL_MAX);
        end else begin
            n_value = sh_age[VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_value <= n_value;
        end
    end

endmodule

// ===== tb/bgi_checker.sv =====
// result checker for the bilinear grid interpolator: watches both channels and the
// register port, keeps its own grid and registers, predicts each query result
// depends on bgi_pkg, bgi_req_if, bgi_rsp_if
`timescale 1ns / 100ps

module bgi_checker import bgi_pkg::*; #(
    parameter int MAX_MAG_POINTS  = BGI_MAX_MAG_DEF,
    parameter int MAX_TIME_POINTS = BGI_MAX_TIME_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bgi_req_if                    i_req,
    bgi_rsp_if                    i_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending
);

    localparam longint ONE_Q16 = longint'(1) <<< FRAC_SHIFT;

    logic        [CNT_W-1:0] mag_count;
    logic        [CNT_W-1:0] time_count;
    logic signed [VAL_W-1:0] mag_origin;
    logic        [VAL_W-1:0] mag_step_inv;
    logic        [VAL_W-1:0] time_step_inv;
    logic        [VAL_W-1:0] grid_q16 [MAX_TIME_POINTS * MAX_MAG_POINTS];
    logic        [VAL_W-1:0] expected_values [$];
    int                      mismatch_count = 0;

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint bin_of(input longint pos, input longint n);
        if (pos < 0)
            return 0;
        return (pos >>> FRAC_SHIFT) > n - 2 ? n - 2 : (pos >>> FRAC_SHIFT);
    endfunction

    function automatic longint blend(input longint a, input longint b, input longint f);
        return (a * ONE_Q16 + f * (b - a) + ROUND_HALF) >>> FRAC_SHIFT;
    endfunction

    function automatic longint entry(input longint r, input longint c);
        return longint'(grid_q16[int'(r) * MAX_MAG_POINTS + int'(c)]);
    endfunction

    function automatic logic [VAL_W-1:0] interpolate(input logic signed [VAL_W-1:0] mag,
                                                     input logic [VAL_W-1:0] age);
        longint nm, nt, mpos, tpos, mi, ti, mf, tf, lo, hi, v;
        nm   = clamp(longint'(mag_count), 2, MAX_MAG_POINTS);
        nt   = clamp(longint'(time_count), 2, MAX_TIME_POINTS);
        mpos = (longint'(mag) - longint'(mag_origin)) * longint'(mag_step_inv);
        tpos = longint'(age) * longint'(time_step_inv);
        mi   = bin_of(mpos, nm);
        ti   = bin_of(tpos, nt);
        mf   = mpos - mi * ONE_Q16;
        tf   = tpos - ti * ONE_Q16;
        lo   = clamp(blend(entry(ti, mi), entry(ti, mi + 1), mf), ROW_MIN, ROW_MAX);
        hi   = clamp(blend(entry(ti + 1, mi), entry(ti + 1, mi + 1), mf), ROW_MIN, ROW_MAX);
        v    = clamp(blend(lo, hi, tf), 0, VAL_MAX);
        return v[VAL_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        logic [VAL_W-1:0] want;
        if (!i_rst_n) begin
            mag_count     = MAG_COUNT_RST;
            time_count    = TIME_COUNT_RST;
            mag_origin    = MAG_ORIGIN_RST;
            mag_step_inv  = STEP_INV_RST;
            time_step_inv = STEP_INV_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MAG_COUNT:     mag_count     = i_cfg_data[CNT_W-1:0];
                    CFG_TIME_COUNT:    time_count    = i_cfg_data[CNT_W-1:0];
                    CFG_MAG_ORIGIN:    mag_origin    = i_cfg_data[VAL_W-1:0];
                    CFG_MAG_STEP_INV:  mag_step_inv  = i_cfg_data[VAL_W-1:0];
                    CFG_TIME_STEP_INV: time_step_inv = i_cfg_data[VAL_W-1:0];
                    default: ;
                endcase
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_values.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, i_rsp.value);
                end else begin
                    want = expected_values.pop_front();
                    if (i_rsp.value !== want) begin
                        mismatch_count++;
                        $display("%0t: value mismatch, expected %h, actual %h",
                                 $time, want, i_rsp.value);
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                if (i_req.req_type == REQ_WRITE) begin
                    if (int'(i_req.row) < MAX_TIME_POINTS && int'(i_req.column) < MAX_MAG_POINTS)
                        grid_q16[int'(i_req.row) * MAX_MAG_POINTS + int'(i_req.column)] =
                            i_req.grid_value;
                end else begin
                    expected_values.push_back(interpolate(i_req.magnitude, i_req.age));
                end
            end
        end
        o_errors  <= mismatch_count;
        o_pending <= expected_values.size();
    end

endmodule

// ===== tb/tb_bilinear_grid_interpolator.sv =====
// top of the bilinear grid interpolator testbench: clock, reset, register
// settings and request stimulus, with bgi_checker beside the block
// depends on bgi_pkg, bgi_req_if, bgi_rsp_if, bgi_checker, bilinear_grid_interpolator
`timescale 1ns / 100ps

module tb_bilinear_grid_interpolator;
    import bgi_pkg::*;

    localparam int MAX_MAG       = BGI_MAX_MAG_DEF;
    localparam int MAX_TIME      = BGI_MAX_TIME_DEF;
    localparam int PHASE_ITEMS   = 75;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int IDLE_PCT      = 20;
    localparam int MAG_MIN       = -(2 ** (VAL_W - 1));
    localparam int MAG_MAX       = 2 ** (VAL_W - 1) - 1;

    typedef struct packed {
        logic [CNT_W-1:0] mag_count;
        logic [CNT_W-1:0] time_count;
        logic [VAL_W-1:0] mag_origin;
        logic [VAL_W-1:0] mag_step_inv;
        logic [VAL_W-1:0] time_step_inv;
    } t_grid_setting;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending_count;
    int                    cycle_count = 0;
    int                    sent_count = 0;
    bit                    steady = 1'b0;
    bit                    written [MAX_TIME][MAX_MAG];
    t_grid_setting         cur;
    t_grid_setting         fixed_settings [8];

    bgi_req_if req_ch ();
    bgi_rsp_if rsp_ch ();

    bilinear_grid_interpolator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    bgi_checker u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .i_rsp       (rsp_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (fail_count),
        .o_pending   (pending_count)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(negedge i_clk) begin
        rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("bilinear_grid_interpolator regression: fail");
            $finish;
        end
    end

    function automatic logic [VAL_W-1:0] rand16();
        return VAL_W'($urandom);
    endfunction

    function automatic int clamp_count(input logic [CNT_W-1:0] c, input int hi);
        return int'(c) < 2 ? 2 : (int'(c) > hi ? hi : int'(c));
    endfunction

    function automatic int bin_of(input longint pos, input int n);
        if (pos < 0)
            return 0;
        return (pos >>> FRAC_SHIFT) > n - 2 ? n - 2 : int'(pos >>> FRAC_SHIFT);
    endfunction

    // cell a query lands in, so its four corners can be written beforehand
    function automatic void locate(input logic [VAL_W-1:0] mag, input logic [VAL_W-1:0] age,
                                   output int mi, output int ti);
        longint mpos, tpos;
        mpos = (longint'($signed(mag)) - longint'($signed(cur.mag_origin)))
               * longint'(cur.mag_step_inv);
        tpos = longint'(age) * longint'(cur.time_step_inv);
        mi   = bin_of(mpos, clamp_count(cur.mag_count, MAX_MAG));
        ti   = bin_of(tpos, clamp_count(cur.time_count, MAX_TIME));
    endfunction

    task automatic send_req(input t_req_type kind, input logic [VAL_W-1:0] mag,
                            input logic [VAL_W-1:0] age, input logic [ROWCOL_W-1:0] row,
                            input logic [ROWCOL_W-1:0] col, input logic [VAL_W-1:0] val);
        @(negedge i_clk);
        if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(negedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= kind;
        req_ch.magnitude  <= mag;
        req_ch.age        <= age;
        req_ch.row        <= row;
        req_ch.column     <= col;
        req_ch.grid_value <= val;
        do @(posedge i_clk); while (!req_ch.ready);
        sent_count++;
    endtask

    task automatic send_write(input logic [ROWCOL_W-1:0] row, input logic [ROWCOL_W-1:0] col,
                              input logic [VAL_W-1:0] val);
        send_req(REQ_WRITE, rand16(), rand16(), row, col, val);
        written[row][col] = 1'b1;
    endtask

    task automatic send_query(input logic [VAL_W-1:0] mag, input logic [VAL_W-1:0] age);
        int mi, ti;
        locate(mag, age, mi, ti);
        for (int dr = 0; dr < 2; dr++)
            for (int dc = 0; dc < 2; dc++)
                if (!written[ti + dr][mi + dc])
                    send_write(ROWCOL_W'(ti + dr), ROWCOL_W'(mi + dc), rand16());
        send_req(REQ_QUERY, mag, age, ROWCOL_W'($urandom), ROWCOL_W'($urandom), rand16());
    endtask

    // query aimed at the grid in use, reaching a little past both ends in magnitude and past the far end in age
    task automatic near_query();
        int               span, off, m, a;
        logic [VAL_W-1:0] mag, age;
        if (cur.mag_step_inv == '0) begin
            mag = rand16();
        end else begin
            span = ((clamp_count(cur.mag_count, MAX_MAG) - 1) << FRAC_SHIFT)
                   / int'(cur.mag_step_inv);
            off  = int'($urandom_range(0, span + span / 8)) - span / 16;
            m    = int'($signed(cur.mag_origin)) + off;
            m    = m < MAG_MIN ? MAG_MIN : (m > MAG_MAX ? MAG_MAX : m);
            mag  = VAL_W'(m);
        end
        if (cur.time_step_inv == '0) begin
            age = rand16();
        end else begin
            span = ((clamp_count(cur.time_count, MAX_TIME) - 1) << FRAC_SHIFT)
                   / int'(cur.time_step_inv);
            a    = int'($urandom_range(0, span + span / 8));
            age  = VAL_W'(a > VAL_MAX ? VAL_MAX : a);
        end
        send_query(mag, age);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic apply_setting(input t_grid_setting s);
        cfg_write(CFG_MAG_COUNT, {(CFG_DATA_W - CNT_W)'($urandom), s.mag_count});
        cfg_write(CFG_TIME_COUNT, {(CFG_DATA_W - CNT_W)'($urandom), s.time_count});
        cfg_write(CFG_MAG_ORIGIN, s.mag_origin);
        cfg_write(CFG_MAG_STEP_INV, s.mag_step_inv);
        cfg_write(CFG_TIME_STEP_INV, s.time_step_inv);
        cur = s;
    endtask

    // no request in flight, results all back, write requests settled
    task automatic drain();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (pending_count != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // at least n requests in all, corner writes ahead of queries included
    task automatic run_phase(input int n);
        int pick, stop;
        stop = sent_count + n;
        while (sent_count < stop) begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
                send_write(ROWCOL_W'($urandom), ROWCOL_W'($urandom), rand16());
            else if (pick < 25)
                send_write(ROWCOL_W'($urandom_range(0, clamp_count(cur.time_count, MAX_TIME) - 1)),
                           ROWCOL_W'($urandom_range(0, clamp_count(cur.mag_count, MAX_MAG) - 1)),
                           rand16());
            else if (pick < 40)
                send_query(rand16(), rand16());
            else
                near_query();
        end
    endtask

    initial begin
        t_grid_setting s;
        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_WRITE;
        req_ch.magnitude  = '0;
        req_ch.age        = '0;
        req_ch.row        = '0;
        req_ch.column     = '0;
        req_ch.grid_value = '0;
        cur = '{MAG_COUNT_RST, TIME_COUNT_RST, MAG_ORIGIN_RST, STEP_INV_RST, STEP_INV_RST};
        fixed_settings = '{
            '{7'd2,   7'd2,   16'h0000, 16'h0100, 16'h0100},
            '{7'd64,  7'd64,  16'h8000, 16'h0200, 16'h0100},
            '{7'd0,   7'd127, 16'h7FFF, 16'hFFFF, 16'hFFFF},
            '{7'd1,   7'd65,  16'hFF00, 16'h0000, 16'h0000},
            '{7'd16,  7'd8,   16'h1000, 16'h0080, 16'h0040},
            '{7'd127, 7'd1,   16'hF000, 16'h0400, 16'h2000},
            '{7'd33,  7'd40,  16'h0200, 16'h0010, 16'h0008},
            '{7'd5,   7'd64,  16'h8000, 16'h0001, 16'hFFFF}
        };

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // unused register indexes must leave the defaults alone
        for (int idx = int'(CFG_TIME_STEP_INV) + 1; idx < 2 ** CFG_IDX_W; idx++)
            cfg_write(CFG_IDX_W'(idx), rand16());

        // default registers: node hits, centre, far extrapolation both ways
        send_write(6'd0, 6'd0, 16'h0000);
        send_write(6'd0, 6'd1, 16'hFFFF);
        send_write(6'd1, 6'd0, 16'hFFFF);
        send_write(6'd1, 6'd1, 16'h8000);
        send_write(6'd63, 6'd63, 16'hFFFF);
        send_write(6'd62, 6'd62, 16'h0000);
        send_query(16'h0000, 16'h0000);
        send_query(16'h0080, 16'h0080);
        send_query(16'h0100, 16'h0000);
        send_query(16'hFF80, 16'h0040);
        send_query(16'h8000, 16'h0000);
        send_query(16'h7FFF, 16'hFFFF);
        send_query(16'h3F00, 16'h3F00);
        send_write(6'd0, 6'd0, 16'h1234);
        send_query(16'h0000, 16'h0000);
        send_query(16'h3E80, 16'h0080);
        drain();

        for (int p = 0; p < 8; p++) begin
            apply_setting(fixed_settings[p]);
            steady = (p == 1);
            run_phase(PHASE_ITEMS);
            drain();
        end
        steady = 1'b0;

        repeat (4) begin
            s.mag_count     = CNT_W'($urandom);
            s.time_count    = CNT_W'($urandom);
            s.mag_origin    = rand16();
            s.mag_step_inv  = $urandom_range(0, 1) ? VAL_W'($urandom_range(1, 1024)) : rand16();
            s.time_step_inv = $urandom_range(0, 1) ? VAL_W'($urandom_range(1, 1024)) : rand16();
            apply_setting(s);
            run_phase(PHASE_ITEMS);
            drain();
        end

        @(negedge i_clk);
        if (fail_count == 0 && pending_count == 0)
            $display("bilinear_grid_interpolator regression: pass");
        else
            $display("bilinear_grid_interpolator regression: fail");
        $finish;
    end

endmodule

// ===== bilinear_grid_interpolator.f =====
src/bgi_pkg.sv
src/bgi_req_if.sv
src/bgi_rsp_if.sv
src/bgi_cfg.sv
src/bgi_locate.sv
src/bgi_grid.sv
src/bgi_blend.sv
src/bilinear_grid_interpolator.sv
tb/bgi_checker.sv
tb/tb_bilinear_grid_interpolator.sv
